// File: sv/uwa_pkg.sv
// Shared types, constants and register codes for the upwind advection stencil.
`timescale 1ns / 1ps
package uwa_pkg;
    localparam int MAX_COLS  = 1024;
    localparam int FRAC_BITS = 16;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int CNT_W     = COL_W + 1;
    localparam int ROW_W     = 17;
    localparam int NROW_W    = 16;
    localparam int NCOL_W    = 10;
    localparam int DIFF_W    = 36;
    localparam int MAG_W     = 35;
    localparam int PROD_W    = 64 - FRAC_BITS;
    localparam int SCL_W     = 35 + 32 - FRAC_BITS + 1;

    // configuration register indexes
    localparam logic [2:0] CFG_ROWS  = 3'd0;
    localparam logic [2:0] CFG_COLS  = 3'd1;
    localparam logic [2:0] CFG_GHOST = 3'd2;
    localparam logic [2:0] CFG_INVDX = 3'd3;
    localparam logic [2:0] CFG_INVDY = 3'd4;

    typedef logic [4:0][31:0] t_tap5;

    // effective frame geometry after clamping
    typedef struct packed {
        logic [2:0]        g;
        logic [NROW_W-1:0] nrow;
        logic [CNT_W-1:0]  ncol;
        logic [CNT_W-1:0]  width;
        logic [ROW_W-1:0]  height;
    } t_geom;

    // cross stencil for one centre point
    typedef struct packed {
        logic  valid;
        logic  last;
        t_tap5 ux;
        t_tap5 vx;
        t_tap5 uy;
        t_tap5 vy;
    } t_taps;

    // scaled derivatives for one centre point
    typedef struct packed {
        logic        valid;
        logic        last;
        logic [31:0] u0;
        logic [31:0] v0;
        logic [31:0] dudx;
        logic [31:0] dvdx;
        logic [31:0] dudy;
        logic [31:0] dvdy;
    } t_deriv;
endpackage

// File: sv/upwind2_advection_stencil_core.sv
// Top level: configuration registers, geometry clamping and the stencil pipeline.
// Pipeline: 7 register stages; a result passes through all of them after the transfer of the
// cell two rows below its centre, and is delayed further by any output stall.
// Throughput: one cell per cycle; every stage advances together whenever the
// output register is empty or being taken, so a stall holds the whole pipeline.
// Reset: counters and valid bits clear; configuration returns to 64x64 interior,
// two ghost layers, both inverse spacings 0.5. Line stores are not cleared.
`timescale 1ns / 1ps
module upwind2_advection_stencil_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_u_sample,
    input  logic [31:0] i_v_sample,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_adv_u,
    output logic [31:0] o_adv_v,
    output logic        o_frame_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int CW = uwa_pkg::CNT_W;
    localparam int RW = uwa_pkg::ROW_W;

    logic [15:0] r_rows;
    logic [9:0]  r_cols;
    logic [2:0]  r_ghost;
    logic [31:0] r_inv_dx, r_inv_dy;
    logic        en;
    logic [2:0]  g;
    logic [CW-1:0] ncol_sum;
    uwa_pkg::t_geom  geom;
    uwa_pkg::t_taps  taps;
    uwa_pkg::t_deriv deriv;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows   <= 16'd64;
            r_cols   <= 10'd64;
            r_ghost  <= 3'd2;
            r_inv_dx <= 32'd32768;
            r_inv_dy <= 32'd32768;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                uwa_pkg::CFG_ROWS:  r_rows   <= i_cfg_data[15:0];
                uwa_pkg::CFG_COLS:  r_cols   <= i_cfg_data[9:0];
                uwa_pkg::CFG_GHOST: r_ghost  <= i_cfg_data[2:0];
                uwa_pkg::CFG_INVDX: r_inv_dx <= i_cfg_data;
                uwa_pkg::CFG_INVDY: r_inv_dy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp the geometry into what the line stores hold
    always_comb begin
        g = (r_ghost < 3'd2) ? 3'd2 : ((r_ghost > 3'd4) ? 3'd4 : r_ghost);
        ncol_sum = CW'(r_cols) + CW'({g, 1'b0});
        geom.g    = g;
        geom.nrow = (r_rows == '0) ? 16'd1 : r_rows;
        if (ncol_sum > CW'(uwa_pkg::MAX_COLS))
            geom.ncol = CW'(uwa_pkg::MAX_COLS) - CW'({g, 1'b0});
        else if (r_cols == '0)
            geom.ncol = CW'(1);
        else
            geom.ncol = CW'(r_cols);
        geom.width  = geom.ncol + CW'({g, 1'b0});
        geom.height = RW'(geom.nrow) + RW'({g, 1'b0});
    end

    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    uwa_line_buf u_line_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_u     (i_u_sample),
        .i_v     (i_v_sample),
        .i_geom  (geom),
        .o_taps  (taps)
    );

    uwa_diff_scale u_diff_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_taps   (taps),
        .i_inv_dx (r_inv_dx),
        .i_inv_dy (r_inv_dy),
        .o_deriv  (deriv)
    );

    uwa_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_deriv (deriv),
        .o_valid (o_out_valid),
        .o_adv_u (o_adv_u),
        .o_adv_v (o_adv_v),
        .o_last  (o_frame_last)
    );
endmodule

// File: sv/uwa_line_buf.sv
// Frame counters, four-row line stores and the stencil window.
`timescale 1ns / 1ps
module uwa_line_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [31:0]         i_u,
    input  logic [31:0]         i_v,
    input  uwa_pkg::t_geom      i_geom,
    output uwa_pkg::t_taps      o_taps
);
    localparam int ROW_W = uwa_pkg::ROW_W;
    localparam int CNT_W = uwa_pkg::CNT_W;
    localparam int COL_W = uwa_pkg::COL_W;

    logic [CNT_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [CNT_W-1:0] col_now, col_inc;
    logic [ROW_W-1:0] row_pre, row_now, row_inc;
    logic [CNT_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic             interior, last;
    logic [COL_W-1:0] addr, addr_ahead;

    logic [31:0] mem_u [4][uwa_pkg::MAX_COLS];
    logic [31:0] mem_v [4][uwa_pkg::MAX_COLS];
    logic [31:0] r_rd_u [4];
    logic [31:0] r_rd_v [4];
    logic [31:0] r_la_u [4];
    logic [31:0] r_la_v [4];

    logic        r_a_valid, r_a_int, r_a_last;
    logic [1:0]  r_a_bank;
    logic [31:0] r_a_u, r_a_v;

    uwa_pkg::t_tap5 cur_u, cur_v;
    logic [31:0]    ahead_u, ahead_v;
    logic [31:0]    r_hist_u [2];
    logic [31:0]    r_hist_v [2];
    logic [31:0]    r_prev_la_u, r_prev_la_v;
    uwa_pkg::t_taps r_taps;

    // position of the incoming cell, wrapping if geometry shrank
    always_comb begin
        col_now = (r_col >= i_geom.width) ? '0 : r_col;
        row_pre = (r_col >= i_geom.width) ? r_row + 1'b1 : r_row;
        row_now = (row_pre >= i_geom.height) ? '0 : row_pre;
        col_inc = col_now + 1'b1;
        row_inc = row_now + 1'b1;
        if (col_inc >= i_geom.width) begin
            n_col = '0;
            n_row = (row_inc >= i_geom.height) ? '0 : row_inc;
        end else begin
            n_col = col_inc;
            n_row = row_now;
        end
        // centre sits two rows above the incoming cell, same column
        interior = (row_now >= ROW_W'(i_geom.g) + 17'd2)
                && (row_now - 17'd2 < ROW_W'(i_geom.g) + ROW_W'(i_geom.nrow))
                && (col_now >= CNT_W'(i_geom.g))
                && (col_now < CNT_W'(i_geom.g) + i_geom.ncol);
        last = (row_now - 17'd2 == ROW_W'(i_geom.g) + ROW_W'(i_geom.nrow) - 17'd1)
            && (col_now == CNT_W'(i_geom.g) + i_geom.ncol - 11'd1);
        addr       = col_now[COL_W-1:0];
        addr_ahead = addr + COL_W'(2);
    end

    // counters and first stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            if (i_valid) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // line stores: read all rows at this column and two columns ahead, write current row
    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            for (int b = 0; b < 4; b++) begin
                r_rd_u[b] <= mem_u[b][addr];
                r_rd_v[b] <= mem_v[b][addr];
                r_la_u[b] <= mem_u[b][addr_ahead];
                r_la_v[b] <= mem_v[b][addr_ahead];
                if (row_now[1:0] == 2'(b)) begin
                    mem_u[b][addr] <= i_u;
                    mem_v[b][addr] <= i_v;
                end
            end
            r_a_int  <= interior;
            r_a_last <= last;
            r_a_bank <= row_now[1:0];
            r_a_u    <= i_u;
            r_a_v    <= i_v;
        end
    end

    // column vector rows r-4..r in order, and the centre row two columns ahead
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            cur_u[k] = r_rd_u[2'(r_a_bank + 2'(k))];
            cur_v[k] = r_rd_v[2'(r_a_bank + 2'(k))];
        end
        cur_u[4] = r_a_u;
        cur_v[4] = r_a_v;
        ahead_u  = r_la_u[2'(r_a_bank + 2'd2)];
        ahead_v  = r_la_v[2'(r_a_bank + 2'd2)];
    end

    // window shift and stencil capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps.valid <= 1'b0;
        end else if (i_en) begin
            r_taps.valid <= r_a_valid && r_a_int;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && r_a_valid) begin
            r_taps.last <= r_a_last;
            r_taps.ux   <= cur_u;
            r_taps.vx   <= cur_v;
            r_taps.uy   <= {ahead_u, r_prev_la_u, cur_u[2], r_hist_u[0], r_hist_u[1]};
            r_taps.vy   <= {ahead_v, r_prev_la_v, cur_v[2], r_hist_v[0], r_hist_v[1]};
            r_hist_u[0] <= cur_u[2];
            r_hist_u[1] <= r_hist_u[0];
            r_hist_v[0] <= cur_v[2];
            r_hist_v[1] <= r_hist_v[0];
            r_prev_la_u <= ahead_u;
            r_prev_la_v <= ahead_v;
        end
    end

    assign o_taps = r_taps;
endmodule

// File: sv/uwa_diff_scale.sv
// Upwind differences and scaling by the inverse grid spacings.
`timescale 1ns / 1ps
module uwa_diff_scale (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  uwa_pkg::t_taps  i_taps,
    input  logic [31:0]     i_inv_dx,
    input  logic [31:0]     i_inv_dy,
    output uwa_pkg::t_deriv o_deriv
);
    localparam int DW = uwa_pkg::DIFF_W;
    localparam int MW = uwa_pkg::MAG_W;
    localparam int FB = uwa_pkg::FRAC_BITS;
    localparam int SW = uwa_pkg::SCL_W;

    function automatic logic [DW-1:0] sx(input logic [31:0] x);
        return {{(DW-32){x[31]}}, x};
    endfunction

    // one-sided three-point difference, side picked by the velocity sign
    function automatic logic [DW-1:0] upw(input uwa_pkg::t_tap5 t, input logic neg_vel);
        logic [DW-1:0] d;
        if (!neg_vel)
            d = (sx(t[2]) << 1) + sx(t[2]) - (sx(t[1]) << 2) + sx(t[0]);
        else
            d = (sx(t[3]) << 2) - (sx(t[2]) << 1) - sx(t[2]) - sx(t[4]);
        return d;
    endfunction

    logic [DW-1:0] dd [4];
    logic [MW:0] dq [4];
    logic        r_d_valid, r_d_last;
    logic [31:0] r_d_u0, r_d_v0;
    logic [MW-1:0] r_d_mag [4];
    logic          r_d_neg [4];

    logic        r_m_valid, r_m_last;
    logic [31:0] r_m_u0, r_m_v0;
    logic [63:0] r_m_lo [4];
    logic [34:0] r_m_hi [4];
    logic        r_m_neg [4];

    logic [SW-1:0] mag [4];
    logic [31:0]   sat [4];
    uwa_pkg::t_deriv r_out;

    // raw differences, then sign and magnitude
    always_comb begin
        dd[0] = upw(i_taps.ux, i_taps.ux[2][31]);
        dd[1] = upw(i_taps.vx, i_taps.ux[2][31]);
        dd[2] = upw(i_taps.uy, i_taps.vx[2][31]);
        dd[3] = upw(i_taps.vy, i_taps.vx[2][31]);
        for (int k = 0; k < 4; k++)
            dq[k] = {dd[k][DW-1], MW'(dd[k][DW-1] ? (~dd[k] + 1'b1) : dd[k])};
    end

    // valid bits for the three stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid   <= 1'b0;
            r_m_valid   <= 1'b0;
            r_out.valid <= 1'b0;
        end else if (i_en) begin
            r_d_valid   <= i_taps.valid;
            r_m_valid   <= r_d_valid;
            r_out.valid <= r_m_valid;
        end
    end

    // difference stage, multiply stage (split product), saturate stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_last <= i_taps.last;
            r_d_u0   <= i_taps.ux[2];
            r_d_v0   <= i_taps.vx[2];
            for (int k = 0; k < 4; k++) begin
                r_d_mag[k] <= dq[k][MW-1:0];
                r_d_neg[k] <= dq[k][MW];
            end
            r_m_last <= r_d_last;
            r_m_u0   <= r_d_u0;
            r_m_v0   <= r_d_v0;
            for (int k = 0; k < 4; k++) begin
                r_m_lo[k]  <= 64'(r_d_mag[k][31:0]) * 64'((k < 2) ? i_inv_dx : i_inv_dy);
                r_m_hi[k]  <= 35'(r_d_mag[k][MW-1:32]) * 35'((k < 2) ? i_inv_dx : i_inv_dy);
                r_m_neg[k] <= r_d_neg[k];
            end
            r_out.last <= r_m_last;
            r_out.u0   <= r_m_u0;
            r_out.v0   <= r_m_v0;
            r_out.dudx <= sat[0];
            r_out.dvdx <= sat[1];
            r_out.dudy <= sat[2];
            r_out.dvdy <= sat[3];
        end
    end

    // recombine partial products and saturate the signed magnitude
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            mag[k] = (SW'(r_m_hi[k]) << (32 - FB)) + SW'(r_m_lo[k] >> FB);
            if (r_m_neg[k])
                sat[k] = (mag[k] > SW'(33'h080000000)) ? 32'h80000000 : (~mag[k][31:0] + 1'b1);
            else
                sat[k] = (mag[k] > SW'(32'h7fffffff)) ? 32'h7fffffff : mag[k][31:0];
        end
    end

    assign o_deriv = r_out;
endmodule

// File: sv/uwa_accum.sv
// Velocity times derivative products, sum and saturation to the output register.
`timescale 1ns / 1ps
module uwa_accum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  uwa_pkg::t_deriv i_deriv,
    output logic            o_valid,
    output logic [31:0]     o_adv_u,
    output logic [31:0]     o_adv_v,
    output logic            o_last
);
    localparam int PW = uwa_pkg::PROD_W;
    localparam int SW = PW + 2;
    localparam int FB = uwa_pkg::FRAC_BITS;

    function automatic logic [31:0] mabs(input logic [31:0] x);
        return x[31] ? (~x + 1'b1) : x;
    endfunction

    logic          r_p_valid, r_p_last;
    logic [PW-1:0] r_p [4];
    logic          r_p_neg [4];
    logic [31:0]   a_in [4];
    logic [31:0]   b_in [4];
    logic [63:0]   prod [4];
    logic signed [SW-1:0] term [4];
    logic signed [SW-1:0] sum_u, sum_v;
    logic          r_valid, r_last;
    logic [31:0]   r_adv_u, r_adv_v;

    function automatic logic [31:0] sat32(input logic signed [SW-1:0] x);
        if (x > $signed(SW'(32'h7fffffff)))
            return 32'h7fffffff;
        if (x < -$signed(SW'(33'h080000000)))
            return 32'h80000000;
        return x[31:0];
    endfunction

    // u0*dudx, v0*dudy, u0*dvdx, v0*dvdy as magnitudes
    always_comb begin
        a_in[0] = i_deriv.u0; b_in[0] = i_deriv.dudx;
        a_in[1] = i_deriv.v0; b_in[1] = i_deriv.dudy;
        a_in[2] = i_deriv.u0; b_in[2] = i_deriv.dvdx;
        a_in[3] = i_deriv.v0; b_in[3] = i_deriv.dvdy;
        for (int k = 0; k < 4; k++)
            prod[k] = 64'(mabs(a_in[k])) * 64'(mabs(b_in[k]));
    end

    // sign applied after the shift, so products truncate toward zero
    always_comb begin
        for (int k = 0; k < 4; k++)
            term[k] = r_p_neg[k] ? -$signed({2'b00, r_p[k]}) : $signed({2'b00, r_p[k]});
        sum_u = term[0] + term[1];
        sum_v = term[2] + term[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else if (i_en) begin
            r_p_valid <= i_deriv.valid;
            r_valid   <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_last <= i_deriv.last;
            for (int k = 0; k < 4; k++) begin
                r_p[k]     <= prod[k][63:FB];
                r_p_neg[k] <= a_in[k][31] ^ b_in[k][31];
            end
            r_last  <= r_p_last;
            r_adv_u <= sat32(sum_u);
            r_adv_v <= sat32(sum_v);
        end
    end

    assign o_valid = r_valid;
    assign o_adv_u = r_adv_u;
    assign o_adv_v = r_adv_v;
    assign o_last  = r_last;
endmodule
